// ===== sv/fpba_pkg.sv =====
// Package for the fit-policy block allocator.
// Holds payload structs, command/policy/register codes and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package fpba_pkg;

  localparam int NUM_BLOCKS_DEF = 16;
  localparam int AMOUNT_W       = 32;
  localparam int SEL_W          = 4;
  localparam int POLICY_W       = 2;
  localparam int COUNT_W        = 5;
  localparam int CFG_DATA_W     = 5;
  localparam int CFG_IDX_W      = 1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

  typedef struct packed {
    logic                cmd;
    logic [SEL_W-1:0]    block_select;
    logic [AMOUNT_W-1:0] amount;
  } alloc_item_t;

  typedef struct packed {
    logic                granted;
    logic [SEL_W-1:0]    chosen_block;
    logic [AMOUNT_W-1:0] left_over;
  } alloc_result_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WB
  } seq_state_t;

endpackage

// ===== sv/fpba_fit_cmp.sv =====
// Shared compare unit: decides whether a scanned block replaces the current pick.
// Depends on fpba_pkg.
`timescale 1ns / 1ps

module fpba_fit_cmp import fpba_pkg::*; (
  input  logic [POLICY_W-1:0] policy,
  input  logic [AMOUNT_W-1:0] cap,
  input  logic [AMOUNT_W-1:0] amount,
  input  logic [AMOUNT_W-1:0] best,
  input  logic                have,
  output logic                take
);

  logic fits;
  logic prefers;

  assign fits = (cap >= amount);

  always_comb begin
    case (policy)
      POLICY_BEST:  prefers = (cap < best);
      POLICY_WORST: prefers = (cap > best);
      default:      prefers = 1'b0;
    endcase
  end

  assign take = fits && (!have || prefers);

endmodule

// ===== sv/fit_policy_block_allocator.sv =====
// Fit-policy block allocator top level: capacity memory, scan sequencer, config.
// Depends on fpba_pkg and fpba_fit_cmp.
//
//  channel | signals                      | transfer
//  --------+------------------------------+------------------------------------
//  input   | start, busy, item            | start high and busy low at clk edge
//  result  | done, result                 | done high for one cycle, no stall
//  config  | cfg_we, cfg_index, cfg_data  | cfg_we high at clk edge
//
// A load is taken while idle; its result appears the next cycle and busy stays low.
// An allocate holds busy through scan and write-back. The scan reads the first used
// blocks (used = min(block_count, NUM_BLOCKS)) one at a time through the single read
// port and comparator, then does the last compare and one empty check (only the check
// when no block is in use). The result appears in the cycle after write-back.
// Synchronous active-high reset clears control state; the capacity memory is
// not cleared. The result side cannot stall; results are shown exactly once.
`timescale 1ns / 1ps

module fit_policy_block_allocator import fpba_pkg::*; #(
  parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  alloc_item_t           item,
  output logic                  done,
  output alloc_result_t         result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

  logic [AMOUNT_W-1:0] mem [NUM_BLOCKS];
  logic [AMOUNT_W-1:0] rd_data;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [AMOUNT_W-1:0] mem_wdata;

  logic [POLICY_W-1:0] fit_policy;
  logic [COUNT_W-1:0]  block_count;

  seq_state_t          state;
  seq_state_t          state_next;
  alloc_item_t         req;
  logic [CNT_W-1:0]    addr;
  logic                cmp_vld;
  logic [IDX_W-1:0]    cmp_idx;
  logic                found;
  logic [IDX_W-1:0]    pick;
  logic [AMOUNT_W-1:0] best_cap;
  logic [CNT_W-1:0]    used;
  logic                accept;
  logic                load_ok;
  logic                scan_rd;
  logic                take;
  logic [AMOUNT_W-1:0] new_cap;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign load_ok = (32'(item.block_select) < 32'(NUM_BLOCKS));
  assign scan_rd = (state == S_SCAN) && (addr < used);
  assign new_cap = best_cap - req.amount;

  always_comb begin
    if (32'(block_count) > 32'(NUM_BLOCKS)) begin
      used = CNT_W'(NUM_BLOCKS);
    end else begin
      used = CNT_W'(block_count);
    end
  end

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy  <= POLICY_FIRST;
      block_count <= COUNT_W'(NUM_BLOCKS_DEF);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIT_POLICY:  fit_policy  <= cfg_data[POLICY_W-1:0];
        REG_BLOCK_COUNT: block_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // capacity memory: one write port, one registered read port
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = IDX_W'(item.block_select);
    mem_wdata = item.amount;
    if (accept && item.cmd == CMD_LOAD && load_ok) begin
      mem_we = 1'b1;
    end else if (state == S_WB && found) begin
      mem_we    = 1'b1;
      mem_waddr = pick;
      mem_wdata = new_cap;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[addr[IDX_W-1:0]];
  end

  fpba_fit_cmp u_cmp (
    .policy (fit_policy),
    .cap    (rd_data),
    .amount (req.amount),
    .best   (best_cap),
    .have   (found),
    .take   (take)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && item.cmd == CMD_ALLOC) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!scan_rd && !cmp_vld) begin
          state_next = S_WB;
        end
      end
      S_WB:    state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done    <= 1'b0;
      cmp_vld <= 1'b0;
      found   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req     <= item;
            addr    <= '0;
            cmp_vld <= 1'b0;
            found   <= 1'b0;
            if (item.cmd == CMD_LOAD) begin
              done                <= 1'b1;
              result.granted      <= 1'b0;
              result.chosen_block <= item.block_select;
              result.left_over    <= load_ok ? item.amount : '0;
            end
          end
        end
        S_SCAN: begin
          if (scan_rd) begin
            addr <= addr + CNT_W'(1);
          end
          cmp_vld <= scan_rd;
          cmp_idx <= addr[IDX_W-1:0];
          if (cmp_vld && take) begin
            found    <= 1'b1;
            pick     <= cmp_idx;
            best_cap <= rd_data;
          end
        end
        S_WB: begin
          done <= 1'b1;
          if (found) begin
            result.granted      <= 1'b1;
            result.chosen_block <= SEL_W'(pick);
            result.left_over    <= new_cap;
          end else begin
            result.granted      <= 1'b0;
            result.chosen_block <= '0;
            result.left_over    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_WB || (accept && item.cmd == CMD_LOAD)))
    else $error("result strobe without a finished transfer");

  a_wb_done: assert property (@(posedge clk) disable iff (rst)
    state == S_WB |=> (state == S_IDLE && done))
    else $error("write-back did not deliver a result");

  a_cmp_scan: assert property (@(posedge clk) disable iff (rst)
    cmp_vld |-> state == S_SCAN)
    else $error("compare pending outside scan");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for fit_policy_block_allocator: directed table, then random phases.
// A capacity mirror predicts results rows don't give. Depends on fpba_pkg and the block RTL.
`timescale 1ns / 1ps

module tb_top;
  import fpba_pkg::*;

  localparam int NBLK = NUM_BLOCKS_DEF;
  localparam int SETTLE_CYC = 24;
  localparam int DRAIN_LIMIT = 4000;
  localparam logic [POLICY_W-1:0] POLICY_RSVD = 2'd3;

  typedef enum logic {ROW_CFG, ROW_XFER} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    alloc_item_t           it;
    bit                    typed;
    alloc_result_t         res;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  alloc_item_t           item;
  logic                  done;
  alloc_result_t         result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  logic [AMOUNT_W-1:0]   cap_mirror [NBLK];
  logic [POLICY_W-1:0]   policy_mirror;
  logic [COUNT_W-1:0]    count_mirror;
  alloc_result_t         placement_q [$];
  dir_row_t              dir_tbl [$];
  int                    fail_count;
  int unsigned           idle_pct;

  fit_policy_block_allocator #(.NUM_BLOCKS(NBLK)) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .item     (item),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic alloc_item_t make_item(logic cmd, logic [SEL_W-1:0] sel,
                                            logic [AMOUNT_W-1:0] amt);
    alloc_item_t it;
    it.cmd = cmd;
    it.block_select = sel;
    it.amount = amt;
    return it;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r = '{kind: ROW_CFG, reg_idx: idx, reg_val: val, it: '0, typed: 1'b0, res: '0};
    return r;
  endfunction

  function automatic dir_row_t xfer_row(logic cmd, logic [SEL_W-1:0] sel,
                                        logic [AMOUNT_W-1:0] amt);
    dir_row_t r;
    r = '{kind: ROW_XFER, reg_idx: '0, reg_val: '0, it: make_item(cmd, sel, amt),
          typed: 1'b0, res: '0};
    return r;
  endfunction

  function automatic dir_row_t chk_row(logic cmd, logic [SEL_W-1:0] sel,
                                       logic [AMOUNT_W-1:0] amt, logic g,
                                       logic [SEL_W-1:0] blk, logic [AMOUNT_W-1:0] lo);
    dir_row_t r;
    r = xfer_row(cmd, sel, amt);
    r.typed = 1'b1;
    r.res.granted = g;
    r.res.chosen_block = blk;
    r.res.left_over = lo;
    return r;
  endfunction

  // Mirror of the block: updates the capacity table and returns the result.
  function automatic alloc_result_t compute_placement(alloc_item_t it);
    alloc_result_t r;
    int unsigned   used;
    bit            found;
    int            pick;
    r = '0;
    if (it.cmd == CMD_LOAD) begin
      cap_mirror[it.block_select] = it.amount;
      r.chosen_block = it.block_select;
      r.left_over = it.amount;
      return r;
    end
    used = (count_mirror > NBLK) ? NBLK : count_mirror;
    found = 1'b0;
    pick = 0;
    for (int j = 0; j < used; j++) begin
      if (cap_mirror[j] >= it.amount) begin
        if (!found) begin
          found = 1'b1;
          pick = j;
        end else if (policy_mirror == POLICY_BEST && cap_mirror[j] < cap_mirror[pick]) begin
          pick = j;
        end else if (policy_mirror == POLICY_WORST && cap_mirror[j] > cap_mirror[pick]) begin
          pick = j;
        end
      end
    end
    if (found) begin
      cap_mirror[pick] = cap_mirror[pick] - it.amount;
      r.granted = 1'b1;
      r.chosen_block = SEL_W'(pick);
      r.left_over = cap_mirror[pick];
    end
    return r;
  endfunction

  function automatic logic [AMOUNT_W-1:0] draw_amount(bit for_request);
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return $urandom;
      4: return for_request ? cap_mirror[$urandom_range(NBLK-1)] : $urandom_range(50);
      default: return for_request ? $urandom_range(300) : $urandom_range(1000);
    endcase
  endfunction

  task automatic send_item(alloc_item_t it, bit given = 1'b0, alloc_result_t given_res = '0);
    logic [63:0]   noise;
    alloc_result_t predicted;
    if ($urandom_range(99) < idle_pct) begin
      noise = {$urandom, $urandom};
      start <= 1'b0;
      item <= noise[$bits(alloc_item_t)-1:0];
      repeat ($urandom_range(1, ($urandom_range(3) == 0) ? 30 : 5)) @(posedge clk);
    end
    item <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predicted = compute_placement(it);
    placement_q.push_back(given ? given_res : predicted);
  endtask

  task automatic drain_results();
    int unsigned waited;
    waited = 0;
    start <= 1'b0;
    while (placement_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYC) @(posedge clk);
    if (placement_q.size() != 0) begin
      $error("%0d expected results never arrived", placement_q.size());
      fail_count++;
      placement_q.delete();
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_FIT_POLICY) begin
      policy_mirror = val[POLICY_W-1:0];
    end else begin
      count_mirror = val[COUNT_W-1:0];
    end
  endtask

  always @(posedge clk) begin : result_check
    alloc_result_t want;
    if (!rst && done) begin
      if (placement_q.size() == 0) begin
        $error("result with no transfer pending: %h", result);
        fail_count++;
      end else begin
        want = placement_q.pop_front();
        if (result.granted !== want.granted) begin
          $error("granted: expected %0d, actual %0d", want.granted, result.granted);
          fail_count++;
        end
        if (result.chosen_block !== want.chosen_block) begin
          $error("chosen_block: expected %0d, actual %0d", want.chosen_block,
                 result.chosen_block);
          fail_count++;
        end
        if (result.left_over !== want.left_over) begin
          $error("left_over: expected %h, actual %h", want.left_over, result.left_over);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("** fit_policy_block_allocator: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned   phase_counts [9];
    alloc_item_t   it;
    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    fail_count = 0;
    idle_pct = 24;
    policy_mirror = POLICY_FIRST;
    count_mirror = COUNT_W'(NBLK);
    foreach (cap_mirror[b]) cap_mirror[b] = '0;

    dir_tbl.push_back(cfg_row(REG_BLOCK_COUNT, 5'd4));
    dir_tbl.push_back(chk_row(CMD_LOAD, 4'd0, 32'd0, 1'b0, 4'd0, 32'd0));
    dir_tbl.push_back(chk_row(CMD_LOAD, 4'd1, '1, 1'b0, 4'd1, '1));
    dir_tbl.push_back(chk_row(CMD_LOAD, 4'd2, 32'd100, 1'b0, 4'd2, 32'd100));
    dir_tbl.push_back(chk_row(CMD_LOAD, 4'd3, 32'd100, 1'b0, 4'd3, 32'd100));
    // first fit from reset; zero request lands on an empty block
    dir_tbl.push_back(chk_row(CMD_ALLOC, 4'd15, 32'd0, 1'b1, 4'd0, 32'd0));
    dir_tbl.push_back(xfer_row(CMD_ALLOC, 4'd9, 32'd50));
    dir_tbl.push_back(chk_row(CMD_ALLOC, 4'd0, '1, 1'b0, 4'd0, 32'd0));
    dir_tbl.push_back(cfg_row(REG_FIT_POLICY, 5'(POLICY_BEST)));
    dir_tbl.push_back(xfer_row(CMD_ALLOC, 4'd5, 32'd100));
    dir_tbl.push_back(xfer_row(CMD_ALLOC, 4'd5, 32'd60));
    dir_tbl.push_back(cfg_row(REG_FIT_POLICY, 5'(POLICY_WORST)));
    dir_tbl.push_back(xfer_row(CMD_ALLOC, 4'd3, 32'd1));
    dir_tbl.push_back(xfer_row(CMD_ALLOC, 4'd3, 32'd40));
    dir_tbl.push_back(cfg_row(REG_FIT_POLICY, 5'(POLICY_RSVD)));
    dir_tbl.push_back(xfer_row(CMD_ALLOC, 4'd0, 32'd30));
    // worst fit tie between blocks 1 and 3
    dir_tbl.push_back(cfg_row(REG_FIT_POLICY, 5'(POLICY_WORST)));
    dir_tbl.push_back(chk_row(CMD_LOAD, 4'd1, 32'd40, 1'b0, 4'd1, 32'd40));
    dir_tbl.push_back(chk_row(CMD_ALLOC, 4'd0, 32'd40, 1'b1, 4'd1, 32'd0));
    dir_tbl.push_back(cfg_row(REG_BLOCK_COUNT, 5'd0));
    dir_tbl.push_back(chk_row(CMD_ALLOC, 4'd7, 32'd0, 1'b0, 4'd0, 32'd0));
    dir_tbl.push_back(cfg_row(REG_BLOCK_COUNT, 5'd1));
    dir_tbl.push_back(chk_row(CMD_LOAD, 4'd0, '1, 1'b0, 4'd0, '1));
    dir_tbl.push_back(chk_row(CMD_ALLOC, 4'd10, '1, 1'b1, 4'd0, 32'd0));
    dir_tbl.push_back(chk_row(CMD_LOAD, 4'd15, '1, 1'b0, 4'd15, '1));
    dir_tbl.push_back(cfg_row(REG_FIT_POLICY, 5'(POLICY_BEST)));
    dir_tbl.push_back(xfer_row(CMD_ALLOC, 4'd0, 32'd0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].kind == ROW_CFG) begin
        drain_results();
        write_reg(dir_tbl[i].reg_idx, dir_tbl[i].reg_val);
      end else begin
        send_item(dir_tbl[i].it, dir_tbl[i].typed, dir_tbl[i].res);
      end
    end

    // every block gets a capacity before any full-table scan
    for (int b = 0; b < NBLK; b++) begin
      send_item(make_item(CMD_LOAD, SEL_W'(b), draw_amount(1'b0)));
    end

    phase_counts = '{16, 31, 0, 1, 16, 7, 31, 16, 2};
    phase_counts[7] = $urandom_range(2, 30);
    for (int p = 0; p < 9; p++) begin
      drain_results();
      write_reg(REG_FIT_POLICY, 5'(p % 4));
      write_reg(REG_BLOCK_COUNT, 5'(phase_counts[p]));
      idle_pct = (p == 4) ? 0 : 24;
      repeat (50) begin
        if ($urandom_range(99) < 30) begin
          it = make_item(CMD_LOAD, SEL_W'($urandom_range(NBLK-1)), draw_amount(1'b0));
        end else begin
          it = make_item(CMD_ALLOC, SEL_W'($urandom), draw_amount(1'b1));
        end
        send_item(it);
        if ($urandom_range(39) == 0) drain_results();
      end
    end

    drain_results();
    if (fail_count == 0) begin
      $display("** fit_policy_block_allocator: PASSED **");
    end else begin
      $display("** fit_policy_block_allocator: FAILED **");
    end
    $finish;
  end

endmodule
